// ===== sv/pli_pkg.sv =====
`timescale 1ns / 1ps
// pli_pkg: shared types, codes and sizes for the positional list block
// no dependencies
package pli_pkg;

	localparam int CAPACITY = 16;

	localparam int KIND_W = 3;
	localparam int POS_W  = 6;
	localparam int DATA_W = 32;
	localparam int STS_W  = 2;
	localparam int LEN_W  = 7;

	localparam logic [KIND_W-1:0] KIND_INS = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DEL = 3'd1;
	localparam logic [KIND_W-1:0] KIND_APP = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RMT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DMP = 3'd4;

	localparam logic [STS_W-1:0] STS_OK     = 2'd0;
	localparam logic [STS_W-1:0] STS_BADPOS = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY  = 2'd2;
	localparam logic [STS_W-1:0] STS_FULL   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SHIFT,
		ST_WRITE,
		ST_RESP,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [STS_W-1:0]  status;
		logic [DATA_W-1:0] item_value;
		logic [LEN_W-1:0]  length;
		logic              last;
	} emit_t;

endpackage

// ===== sv/positional_list_insert_delete.sv =====
`timescale 1ns / 1ps
// positional_list_insert_delete: top level, bounded ordered list edited by position
// depends on pli_pkg and pli_seq
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   kind, position, value
//  out      out  out_valid/out_stall status, item_value, length, last
//
// each command runs to completion before the next is accepted; an append or an insert at the
// tail writes one entry, a delete before the last entry or an insert before the tail first
// moves the entries behind the position one at a time, and a dump reads every entry out in
// order; the entry ram moves one entry per cycle and its read data is registered
// reset clears the entry count; the entry ram has no clearing pass
// out_stall holds the result register and the sequencer waits for it to free up
module positional_list_insert_delete #(
	parameter int CAPACITY = pli_pkg::CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic        [pli_pkg::KIND_W-1:0]  kind,
	input  logic        [pli_pkg::POS_W-1:0]   position,
	input  logic signed [pli_pkg::DATA_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic        [pli_pkg::STS_W-1:0]   status,
	output logic signed [pli_pkg::DATA_W-1:0]  item_value,
	output logic        [pli_pkg::LEN_W-1:0]   length,
	output logic                               last
);

	pli_pkg::emit_t emit;
	logic           out_free;

	logic                       out_valid_q;
	logic [pli_pkg::STS_W-1:0]  status_q;
	logic [pli_pkg::DATA_W-1:0] item_q;
	logic [pli_pkg::LEN_W-1:0]  length_q;
	logic                       last_q;

	assign out_free = !out_valid_q || !out_stall;

	pli_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind    (kind),
		.position(position),
		.value   ($unsigned(value)),
		.out_free(out_free),
		.emit    (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			status_q <= emit.status;
			item_q   <= emit.item_value;
			length_q <= emit.length;
			last_q   <= emit.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign item_value = $signed(item_q);
	assign length     = length_q;
	assign last       = last_q;

endmodule

// ===== sv/pli_ram.sv =====
`timescale 1ns / 1ps
// pli_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/pli_seq.sv =====
`timescale 1ns / 1ps
// pli_seq: sequencer for list edits and dumps, one entry move per cycle through a shared index unit
// depends on pli_pkg and pli_ram
module pli_seq #(
	parameter int CAPACITY = pli_pkg::CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pli_pkg::KIND_W-1:0]  kind,
	input  logic [pli_pkg::POS_W-1:0]   position,
	input  logic [pli_pkg::DATA_W-1:0]  value,
	input  logic                        out_free,
	output pli_pkg::emit_t              emit
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = pli_pkg::LEN_W;

	pli_pkg::state_t state_q, state_d;

	logic [pli_pkg::KIND_W-1:0] kind_q;
	logic [pli_pkg::POS_W-1:0]  pos_q;
	logic [pli_pkg::DATA_W-1:0] val_q;
	logic [CW-1:0]              count_q, count_d;
	logic [pli_pkg::STS_W-1:0]  status_q, status_d;
	logic [AW-1:0]              src_q, src_d;
	logic [AW-1:0]              prev_q, prev_d;
	logic [AW-1:0]              wr_addr_q, wr_addr_d;
	logic [AW-1:0]              emit_idx_q, emit_idx_d;
	logic [AW-1:0]              dst_s1, dst_d;
	logic                       up_q, up_d;
	logic                       issue_q, issue_d;
	logic                       pend_s1, pend_d;
	logic                       data_ok_q, data_ok_d;
	logic                       accept;

	logic                       rd_en, wr_en;
	logic [AW-1:0]              rd_addr, wr_addr;
	logic [pli_pkg::DATA_W-1:0] wr_data, rd_data;

	logic [LW-1:0] pos_l, cnt_l;
	logic [AW-1:0] pos_a, cnt_m1, step, stop;
	logic          can_emit, dump_last;

	pli_ram #(
		.WIDTH(pli_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign in_stall = (state_q != pli_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign pos_l  = LW'(pos_q);
	assign cnt_l  = LW'(count_q);
	assign pos_a  = AW'(pos_q);
	assign cnt_m1 = AW'(count_q - CW'(1));
	// shared index unit
	assign step   = up_q ? (src_q - AW'(1)) : (src_q + AW'(1));
	assign stop   = up_q ? pos_a : cnt_m1;

	assign can_emit  = data_ok_q && out_free;
	assign dump_last = (emit_idx_q == cnt_m1);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		status_d   = status_q;
		src_d      = src_q;
		prev_d     = prev_q;
		wr_addr_d  = wr_addr_q;
		emit_idx_d = emit_idx_q;
		dst_d      = dst_s1;
		up_d       = up_q;
		issue_d    = issue_q;
		pend_d     = 1'b0;
		data_ok_d  = data_ok_q;
		rd_en      = 1'b0;
		rd_addr    = src_q;
		wr_en      = 1'b0;
		wr_addr    = dst_s1;
		wr_data    = rd_data;
		emit       = '0;

		unique case (state_q)
			pli_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = pli_pkg::ST_DECIDE;
				end
			end
			pli_pkg::ST_DECIDE: begin
				status_d = pli_pkg::STS_OK;
				state_d  = pli_pkg::ST_RESP;
				unique case (kind_q)
					pli_pkg::KIND_INS: begin
						if (pos_l > cnt_l) begin
							status_d = pli_pkg::STS_BADPOS;
						end else if (cnt_l >= LW'(CAPACITY)) begin
							status_d = pli_pkg::STS_FULL;
						end else begin
							wr_addr_d = pos_a;
							if (cnt_l > pos_l) begin
								up_d    = 1'b1;
								src_d   = cnt_m1;
								prev_d  = AW'(count_q);
								issue_d = 1'b1;
								state_d = pli_pkg::ST_SHIFT;
							end else begin
								state_d = pli_pkg::ST_WRITE;
							end
						end
					end
					pli_pkg::KIND_DEL: begin
						if (pos_l >= cnt_l) begin
							status_d = pli_pkg::STS_BADPOS;
						end else if ((pos_l + LW'(1)) < cnt_l) begin
							up_d    = 1'b0;
							src_d   = pos_a + AW'(1);
							prev_d  = pos_a;
							issue_d = 1'b1;
							state_d = pli_pkg::ST_SHIFT;
						end else begin
							count_d = count_q - CW'(1);
						end
					end
					pli_pkg::KIND_APP: begin
						if (cnt_l >= LW'(CAPACITY)) begin
							status_d = pli_pkg::STS_FULL;
						end else begin
							wr_addr_d = AW'(count_q);
							state_d   = pli_pkg::ST_WRITE;
						end
					end
					pli_pkg::KIND_RMT: begin
						if (count_q == '0) begin
							status_d = pli_pkg::STS_EMPTY;
						end else begin
							count_d = count_q - CW'(1);
						end
					end
					pli_pkg::KIND_DMP: begin
						if (count_q == '0) begin
							status_d = pli_pkg::STS_EMPTY;
						end else begin
							up_d      = 1'b0;
							src_d     = '0;
							issue_d   = 1'b1;
							data_ok_d = 1'b0;
							state_d   = pli_pkg::ST_DUMP;
						end
					end
					default: begin
						status_d = pli_pkg::STS_OK;
					end
				endcase
			end
			pli_pkg::ST_SHIFT: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = dst_s1;
					wr_data = rd_data;
				end
				if (issue_q) begin
					rd_en   = 1'b1;
					rd_addr = src_q;
					pend_d  = 1'b1;
					dst_d   = prev_q;
					prev_d  = src_q;
					src_d   = step;
					if (src_q == stop) begin
						issue_d = 1'b0;
					end
				end
				if (!issue_q && !pend_s1) begin
					if (up_q) begin
						state_d = pli_pkg::ST_WRITE;
					end else begin
						count_d = count_q - CW'(1);
						state_d = pli_pkg::ST_RESP;
					end
				end
			end
			pli_pkg::ST_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = wr_addr_q;
				wr_data = val_q;
				count_d = count_q + CW'(1);
				state_d = pli_pkg::ST_RESP;
			end
			pli_pkg::ST_RESP: begin
				if (out_free) begin
					emit.valid  = 1'b1;
					emit.status = status_q;
					emit.length = cnt_l;
					emit.last   = 1'b1;
					state_d     = pli_pkg::ST_IDLE;
				end
			end
			pli_pkg::ST_DUMP: begin
				if (can_emit) begin
					emit.valid      = 1'b1;
					emit.status     = pli_pkg::STS_OK;
					emit.item_value = rd_data;
					emit.length     = cnt_l;
					emit.last       = dump_last;
					data_ok_d       = 1'b0;
					if (dump_last) begin
						state_d = pli_pkg::ST_IDLE;
					end
				end
				if (issue_q && (!data_ok_q || can_emit)) begin
					rd_en      = 1'b1;
					rd_addr    = src_q;
					emit_idx_d = src_q;
					src_d      = step;
					data_ok_d  = 1'b1;
					if (src_q == cnt_m1) begin
						issue_d = 1'b0;
					end
				end
			end
			default: begin
				state_d = pli_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pli_pkg::ST_IDLE;
			count_q   <= '0;
			issue_q   <= 1'b0;
			pend_s1   <= 1'b0;
			data_ok_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			issue_q   <= issue_d;
			pend_s1   <= pend_d;
			data_ok_q <= data_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			pos_q  <= position;
			val_q  <= value;
		end
		status_q   <= status_d;
		src_q      <= src_d;
		prev_q     <= prev_d;
		wr_addr_q  <= wr_addr_d;
		emit_idx_q <= emit_idx_d;
		dst_s1     <= dst_d;
		up_q       <= up_d;
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("result produced while output register busy");

	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pli_pkg::ST_DUMP) |=> $stable(count_q))
		else $error("entry count changed during dump");

	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pli_pkg::ST_SHIFT && pend_s1) |-> (LW'(dst_s1) < LW'(CAPACITY)))
		else $error("shift write outside storage");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pli_pkg::ST_IDLE) |-> (!wr_en && !rd_en && !emit.valid))
		else $error("activity while idle");
`endif

endmodule

// ===== test/pli_check.sv =====
`timescale 1ns / 1ps
// pli_check: watches both channels of positional_list_insert_delete, keeps its own copy
// of the list, predicts every result beat and compares it field by field
// depends on pli_pkg
module pli_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic        [pli_pkg::KIND_W-1:0]  kind,
	input  logic        [pli_pkg::POS_W-1:0]   position,
	input  logic signed [pli_pkg::DATA_W-1:0]  value,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic        [pli_pkg::STS_W-1:0]   status,
	input  logic signed [pli_pkg::DATA_W-1:0]  item_value,
	input  logic        [pli_pkg::LEN_W-1:0]   length,
	input  logic                               last,
	output int                                 fail_count,
	output int                                 outstanding
);

	typedef struct {
		logic [pli_pkg::STS_W-1:0]  status;
		logic [pli_pkg::DATA_W-1:0] item_value;
		logic [pli_pkg::LEN_W-1:0]  length;
		logic                       last;
	} list_result_t;

	logic [pli_pkg::DATA_W-1:0] list_entries [pli_pkg::CAPACITY];
	int                         list_count = 0;
	list_result_t               expected_results [$];
	list_result_t               want;
	int                         mismatches = 0;
	int                         queued = 0;

	assign fail_count  = mismatches;
	assign outstanding = queued;

	task automatic push_result(input logic [pli_pkg::STS_W-1:0] st,
			input logic [pli_pkg::DATA_W-1:0] v, input logic fin);
		list_result_t r;
		r.status     = st;
		r.item_value = v;
		r.length     = pli_pkg::LEN_W'(list_count);
		r.last       = fin;
		expected_results.push_back(r);
	endtask

	task automatic predict_beat(input logic [pli_pkg::KIND_W-1:0] k,
			input logic [pli_pkg::POS_W-1:0] p, input logic [pli_pkg::DATA_W-1:0] v);
		logic [pli_pkg::STS_W-1:0] st;
		int                        i;
		st = pli_pkg::STS_OK;
		case (k)
			pli_pkg::KIND_INS: begin
				if (int'(p) > list_count) begin
					st = pli_pkg::STS_BADPOS;
				end else if (list_count >= pli_pkg::CAPACITY) begin
					st = pli_pkg::STS_FULL;
				end else begin
					for (i = list_count; i > int'(p); i--)
						list_entries[i] = list_entries[i-1];
					list_entries[p] = v;
					list_count++;
				end
			end
			pli_pkg::KIND_DEL: begin
				if (int'(p) >= list_count) begin
					st = pli_pkg::STS_BADPOS;
				end else begin
					for (i = int'(p); i + 1 < list_count; i++)
						list_entries[i] = list_entries[i+1];
					list_count--;
				end
			end
			pli_pkg::KIND_APP: begin
				if (list_count >= pli_pkg::CAPACITY) begin
					st = pli_pkg::STS_FULL;
				end else begin
					list_entries[list_count] = v;
					list_count++;
				end
			end
			pli_pkg::KIND_RMT: begin
				if (list_count == 0)
					st = pli_pkg::STS_EMPTY;
				else
					list_count--;
			end
			pli_pkg::KIND_DMP: begin
				if (list_count == 0) begin
					st = pli_pkg::STS_EMPTY;
				end else begin
					for (i = 0; i < list_count; i++)
						push_result(pli_pkg::STS_OK, list_entries[i], i + 1 == list_count);
					return;
				end
			end
			default: ;
		endcase
		push_result(st, '0, 1'b1);
	endtask

	task automatic report_field(input string name, input logic [pli_pkg::DATA_W-1:0] exp_v,
			input logic [pli_pkg::DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_count = 0;
			expected_results.delete();
			queued <= 0;
		end else begin
			// result first: a beat leaving now never belongs to a beat arriving now
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result expected none actual status %0h value %0h",
						$time, status, item_value);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					report_field("status", pli_pkg::DATA_W'(want.status),
						pli_pkg::DATA_W'(status));
					report_field("item_value", want.item_value, item_value);
					report_field("length", pli_pkg::DATA_W'(want.length),
						pli_pkg::DATA_W'(length));
					report_field("last", pli_pkg::DATA_W'(want.last), pli_pkg::DATA_W'(last));
				end
			end
			if (in_valid && !in_stall)
				predict_beat(kind, position, value);
			queued <= expected_results.size();
		end
	end

endmodule

// ===== test/positional_list_insert_delete_tb.sv =====
`timescale 1ns / 1ps
// positional_list_insert_delete_tb: drives directed and random list edits with bursty
// input and patterned output stall, verdict from pli_check
// depends on pli_pkg, pli_check and positional_list_insert_delete
module positional_list_insert_delete_tb;

	localparam int IDLE_LIMIT   = 3000;
	localparam int RANDOM_BEATS = 90;
	localparam int DRAIN_CYCLES = 40;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic        [pli_pkg::KIND_W-1:0] kind = '0;
	logic        [pli_pkg::POS_W-1:0]  position = '0;
	logic signed [pli_pkg::DATA_W-1:0] value = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic        [pli_pkg::STS_W-1:0]  status;
	logic signed [pli_pkg::DATA_W-1:0] item_value;
	logic        [pli_pkg::LEN_W-1:0]  length;
	logic                              last;

	int fail_count;
	int outstanding;
	int burst_left = 0;
	int list_len = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_tick = 0;

	positional_list_insert_delete u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.item_value (item_value),
		.length     (length),
		.last       (last)
	);

	pli_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.item_value  (item_value),
		.length      (length),
		.last        (last),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stall pattern, mode picked anew at random from four patterns
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 50 == 49)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_tick[1];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("positional_list_insert_delete: mismatch");
				$finish;
			end
		end
	end

	task automatic send_beat(input logic [pli_pkg::KIND_W-1:0] k,
			input logic [pli_pkg::POS_W-1:0] p, input logic [pli_pkg::DATA_W-1:0] v);
		int gap;
		bit taken;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		kind     <= k;
		position <= p;
		value    <= v;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		// running length, only to aim positions
		case (k)
			pli_pkg::KIND_INS:
				if (int'(p) <= list_len && list_len < pli_pkg::CAPACITY) list_len++;
			pli_pkg::KIND_DEL: if (int'(p) < list_len) list_len--;
			pli_pkg::KIND_APP: if (list_len < pli_pkg::CAPACITY) list_len++;
			pli_pkg::KIND_RMT: if (list_len > 0) list_len--;
			default: ;
		endcase
	endtask

	function automatic logic [pli_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic rand_beat(input bit growing);
		int                        r;
		logic [pli_pkg::POS_W-1:0] ins_pos;
		logic [pli_pkg::POS_W-1:0] del_pos;
		ins_pos = pli_pkg::POS_W'($urandom_range(0, list_len));
		del_pos = (list_len == 0) ? '0 : pli_pkg::POS_W'($urandom_range(0, list_len - 1));
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// noise: any kind code and any position
			send_beat(pli_pkg::KIND_W'($urandom_range(0, 7)),
				pli_pkg::POS_W'($urandom_range(0, 63)), pick_value());
		end else if (growing) begin
			if (r < 42)      send_beat(pli_pkg::KIND_APP, pli_pkg::POS_W'($urandom), pick_value());
			else if (r < 76) send_beat(pli_pkg::KIND_INS, ins_pos, pick_value());
			else if (r < 83) send_beat(pli_pkg::KIND_DEL, del_pos, pick_value());
			else if (r < 89) send_beat(pli_pkg::KIND_RMT, pli_pkg::POS_W'($urandom), pick_value());
			else             send_beat(pli_pkg::KIND_DMP, pli_pkg::POS_W'($urandom), pick_value());
		end else begin
			if (r < 38)      send_beat(pli_pkg::KIND_DEL, del_pos, pick_value());
			else if (r < 64) send_beat(pli_pkg::KIND_RMT, pli_pkg::POS_W'($urandom), pick_value());
			else if (r < 74) send_beat(pli_pkg::KIND_APP, pli_pkg::POS_W'($urandom), pick_value());
			else if (r < 84) send_beat(pli_pkg::KIND_INS, ins_pos, pick_value());
			else             send_beat(pli_pkg::KIND_DMP, pli_pkg::POS_W'($urandom), pick_value());
		end
	endtask

	initial begin
		bit growing;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		send_beat(pli_pkg::KIND_DMP, '0, '0);
		send_beat(pli_pkg::KIND_RMT, '0, '0);
		send_beat(pli_pkg::KIND_DEL, '0, '0);
		send_beat(pli_pkg::KIND_INS, 6'd1, 32'h1111_1111);
		// fill with extremes, then edit ends and middle
		send_beat(pli_pkg::KIND_INS, '0, 32'h8000_0000);
		send_beat(pli_pkg::KIND_APP, '1, 32'h7fff_ffff);
		send_beat(pli_pkg::KIND_APP, '0, '1);
		send_beat(pli_pkg::KIND_APP, '0, '0);
		send_beat(pli_pkg::KIND_INS, '1, 32'h2222_2222);
		send_beat(pli_pkg::KIND_INS, 6'd4, 32'd5);
		send_beat(pli_pkg::KIND_INS, 6'd2, 32'h1234_5678);
		send_beat(pli_pkg::KIND_DMP, '1, '1);
		send_beat(pli_pkg::KIND_DEL, '1, '0);
		send_beat(pli_pkg::KIND_DEL, 6'd5, '0);
		send_beat(pli_pkg::KIND_DEL, '0, '0);
		send_beat(pli_pkg::KIND_RMT, '1, '1);
		send_beat(pli_pkg::KIND_DMP, '0, '0);
		// unused kind codes
		for (int k = int'(pli_pkg::KIND_DMP) + 1; k < 2 ** pli_pkg::KIND_W; k++)
			send_beat(pli_pkg::KIND_W'(k), '1, '1);
		send_beat(pli_pkg::KIND_DMP, '0, '0);

		growing = 1'b1;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 26 == 25)
				growing = !growing;
			rand_beat(growing);
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("positional_list_insert_delete: match");
		else
			$display("positional_list_insert_delete: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pli_pkg.sv
sv/pli_ram.sv
sv/pli_seq.sv
sv/positional_list_insert_delete.sv
test/pli_check.sv
test/positional_list_insert_delete_tb.sv
